// ===== design/lkvc_pkg.sv =====
// Shared constants, types and control structs of the LRU key-value cache.
package lkvc_pkg;

   localparam int ENTRIES   = 16;
   localparam int KEY_W     = 31;
   localparam int CAP_W     = 5;
   localparam int RANK_W    = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
   localparam int CNT_W     = $clog2(ENTRIES + 1);
   localparam int CMP_W     = (CNT_W > CAP_W) ? CNT_W : CAP_W;

   typedef logic [KEY_W-1:0]  key_type;
   typedef logic [RANK_W-1:0] rank_type;
   typedef logic [CNT_W-1:0]  count_type;
   typedef logic [CAP_W-1:0]  cap_type;
   typedef logic [CMP_W-1:0]  cmp_type;

   localparam cap_type   CAP_RESET  = 5'd16;
   localparam count_type COUNT_FULL = CNT_W'(ENTRIES);

   localparam logic OP_GET = 1'b0;
   localparam logic OP_PUT = 1'b1;

   typedef enum logic {
      ST_IDLE,
      ST_EXEC
   } state_type;

   // Broadcast from the controller to every cell.
   typedef struct packed {
      logic     capture;
      key_type  compare_key;
      logic     update;
      logic     sel_hit;
      logic     sel_victim;
      logic     sel_free;
      logic     write_data;
      logic     age_en;
      logic     age_all;
      rank_type age_limit;
      key_type  key;
      key_type  value;
   } cell_cmd_type;

   // Passed from each cell to the next one up the row.
   typedef struct packed {
      logic     found;
      logic     free_seen;
      rank_type rank;
      key_type  value;
   } cell_chain_type;

endpackage

// ===== design/lkvc_channels.sv =====
// Handshake channel interfaces for requests, responses and the capacity register.
interface lkvc_req_if;
   logic              valid;
   logic              ready;
   logic              op;
   lkvc_pkg::key_type lookup_key;
   lkvc_pkg::key_type store_value;

   modport source (output valid, output op, output lookup_key, output store_value,
                   input ready);
   modport sink   (input valid, input op, input lookup_key, input store_value,
                   output ready);
endinterface

interface lkvc_rsp_if;
   logic              valid;
   logic              ready;
   logic              hit;
   lkvc_pkg::key_type read_value;

   modport source (output valid, output hit, output read_value, input ready);
   modport sink   (input valid, input hit, input read_value, output ready);
endinterface

interface lkvc_csr_if;
   logic              valid;
   logic              ready;
   lkvc_pkg::cap_type capacity_in_use;

   modport source (output valid, output capacity_in_use, input ready);
   modport sink   (input valid, input capacity_in_use, output ready);
endinterface

// ===== design/lkvc_cell.sv =====
// One cache entry: key, value, recency rank and its link in the priority chain.
module lkvc_cell (
   input  logic                     clock,
   input  logic                     reset,
   input  lkvc_pkg::cell_cmd_type   cmd,
   input  lkvc_pkg::cell_chain_type chain_in,
   output lkvc_pkg::cell_chain_type chain_out,
   output logic                     valid
);
   import lkvc_pkg::*;

   logic     valid_ff, valid_in;
   logic     match_ff, match_in;
   rank_type rank_ff, rank_in;
   key_type  key_ff, key_in;
   key_type  value_ff, value_in;

   logic match_first;
   logic free_first;
   logic victim;
   logic is_target;
   logic age;

   always_comb begin
      match_first = match_ff & ~chain_in.found;
      free_first  = ~valid_ff & ~chain_in.free_seen;
      // Ranks of valid entries are distinct, so the oldest one is unique.
      victim      = valid_ff & (rank_ff == cmd.age_limit);
      is_target   = cmd.update & ((cmd.sel_hit & match_first) |
                                  (cmd.sel_victim & victim) |
                                  (cmd.sel_free & free_first));
      age         = cmd.update & cmd.age_en & valid_ff & ~is_target &
                    (cmd.age_all | (rank_ff < cmd.age_limit));

      chain_out.found     = chain_in.found | match_ff;
      chain_out.free_seen = chain_in.free_seen | ~valid_ff;
      chain_out.rank      = chain_in.rank | (match_first ? rank_ff : '0);
      chain_out.value     = chain_in.value | (match_first ? value_ff : '0);
   end

   always_comb begin
      valid_in = valid_ff | is_target;
      match_in = cmd.capture ? (valid_ff && (key_ff == cmd.compare_key)) : match_ff;
      if (is_target) begin
         rank_in = '0;
      end else if (age) begin
         rank_in = rank_type'(rank_ff + 1'b1);
      end else begin
         rank_in = rank_ff;
      end
      key_in   = (is_target && cmd.write_data) ? cmd.key : key_ff;
      value_in = (is_target && cmd.write_data) ? cmd.value : value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
         match_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         match_ff <= match_in;
      end
   end

   always_ff @(posedge clock) begin
      rank_ff  <= rank_in;
      key_ff   <= key_in;
      value_ff <= value_in;
   end

   assign valid = valid_ff;

endmodule

// ===== design/lru_key_value_cache.sv =====
// Steps: capture and key compare on accept, then chain and update; a get's response is registered
// from the update step and then waits. A new request is taken only once the last one is done.
// A get whose earlier response is still untaken holds in the update step until it drains.
// Reset clears all valid bits, the fill count and the response; capacity returns to 16.
// Keys, values and ranks are not reset and are only used while their entry is valid.
module lru_key_value_cache (
   input  logic      clock,
   input  logic      reset,
   lkvc_req_if.sink  req_chan,
   lkvc_rsp_if.source rsp_chan,
   lkvc_csr_if.sink  csr_chan
);
   import lkvc_pkg::*;

   state_type state_ff, state_in;
   logic      op_ff, op_in;
   key_type   key_ff, key_in;
   key_type   value_ff, value_in;
   count_type filled_ff, filled_in;
   cap_type   cap_ff, cap_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      rsp_hit_ff, rsp_hit_in;
   key_type   rsp_value_ff, rsp_value_in;

   cell_cmd_type           cmd;
   cell_chain_type         chain [ENTRIES+1];
   logic [ENTRIES-1:0]     valid_vec;

   logic accept;
   logic stall;
   logic hit;
   logic full;
   logic do_update;
   logic load_rsp;

   assign chain[0] = '0;

   for (genvar i = 0; i < ENTRIES; i++) begin : g_cell
      lkvc_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cmd       (cmd),
         .chain_in  (chain[i]),
         .chain_out (chain[i+1]),
         .valid     (valid_vec[i])
      );
   end

   assign accept = req_chan.valid & req_chan.ready;
   assign hit    = chain[ENTRIES].found;
   assign stall  = (op_ff == OP_GET) && rsp_valid_ff && !rsp_chan.ready;

   always_comb begin
      if (cap_ff == '0) begin
         full = (filled_ff != '0);
      end else begin
         full = (CMP_W'(filled_ff) >= CMP_W'(cap_ff));
      end
      // A capacity above the array size saturates at the array size.
      if (filled_ff == COUNT_FULL) begin
         full = 1'b1;
      end
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!stall) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   // Outputs of the controller and the broadcast to the cells.
   always_comb begin
      req_chan.ready = 1'b0;
      do_update      = 1'b0;
      unique case (state_ff)
         ST_IDLE: req_chan.ready = 1'b1;
         ST_EXEC: do_update      = !stall;
         default: req_chan.ready = 1'b0;
      endcase

      cmd             = '0;
      cmd.capture     = accept;
      cmd.compare_key = req_chan.lookup_key;
      cmd.update      = do_update;
      cmd.key         = key_ff;
      cmd.value       = value_ff;
      if (hit) begin
         cmd.sel_hit    = 1'b1;
         cmd.write_data = (op_ff == OP_PUT);
         cmd.age_en     = 1'b1;
         cmd.age_limit  = chain[ENTRIES].rank;
      end else if (op_ff == OP_PUT) begin
         cmd.write_data = 1'b1;
         cmd.age_en     = 1'b1;
         if (full) begin
            // The oldest valid entry holds rank filled - 1; all others age.
            cmd.sel_victim = 1'b1;
            cmd.age_limit  = rank_type'(filled_ff - 1'b1);
         end else begin
            cmd.sel_free = 1'b1;
            cmd.age_all  = 1'b1;
         end
      end
   end

   always_comb begin
      op_in    = accept ? req_chan.op : op_ff;
      key_in   = accept ? req_chan.lookup_key : key_ff;
      value_in = accept ? req_chan.store_value : value_ff;

      filled_in = filled_ff;
      if (do_update && (op_ff == OP_PUT) && !hit && !full) begin
         filled_in = count_type'(filled_ff + 1'b1);
      end

      cap_in = (csr_chan.valid && csr_chan.ready) ? csr_chan.capacity_in_use : cap_ff;

      load_rsp     = do_update && (op_ff == OP_GET);
      rsp_valid_in = load_rsp ? 1'b1 : (rsp_chan.ready ? 1'b0 : rsp_valid_ff);
      rsp_hit_in   = load_rsp ? hit : rsp_hit_ff;
      rsp_value_in = load_rsp ? chain[ENTRIES].value : rsp_value_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         filled_ff    <= '0;
         cap_ff       <= CAP_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         filled_ff    <= filled_in;
         cap_ff       <= cap_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      key_ff       <= key_in;
      value_ff     <= value_in;
      rsp_hit_ff   <= rsp_hit_in;
      rsp_value_ff <= rsp_value_in;
   end

   assign csr_chan.ready      = 1'b1;
   assign rsp_chan.valid      = rsp_valid_ff;
   assign rsp_chan.hit        = rsp_hit_ff;
   assign rsp_chan.read_value = rsp_value_ff;

`ifndef SYNTHESIS
   a_fill_matches_valid: assert property (@(posedge clock) disable iff (reset)
      $countones(valid_vec) == int'(filled_ff))
      else $error("fill count disagrees with the number of valid entries");

   a_accept_then_exec: assert property (@(posedge clock) disable iff (reset)
      accept |=> (state_ff == ST_EXEC))
      else $error("accepted request did not move to the update step");

   a_rsp_from_exec: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == ST_EXEC) && ($past(op_ff) == OP_GET))
      else $error("response appeared without a get in the update step");

   a_hit_has_value_zero_on_miss: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid_ff && !rsp_hit_ff) |-> (rsp_value_ff == '0))
      else $error("miss response carries a nonzero value");
`endif

endmodule

// ===== tb/sv/lru_key_value_cache_tb.sv =====
// Testbench for the LRU key-value cache: random and directed gets and puts, scoreboard checked.
module lru_key_value_cache_tb;
   timeunit 1ns;
   timeprecision 1ps;

   import lkvc_pkg::*;

   localparam int HOLD_CYCLES  = 60;
   localparam int SETTLE_WAIT  = 8;
   localparam int RANDOM_ITEMS = 84;

   typedef struct {
      key_type key;
      logic    hit;
      key_type value;
   } lookup_result_type;

   // Tracks the cache contents and recency order, and the lookup answers still owed.
   class lookup_checker;
      bit                slot_valid[ENTRIES];
      key_type           slot_key[ENTRIES];
      key_type           slot_value[ENTRIES];
      int unsigned       slot_rank[ENTRIES];
      int unsigned       filled;
      cap_type           capacity;
      lookup_result_type expected_lookups[$];
      int                mismatches;

      function new();
         for (int i = 0; i < ENTRIES; i++) begin
            slot_valid[i] = 1'b0;
            slot_rank[i]  = 0;
         end
         filled     = 0;
         capacity   = CAP_RESET;
         mismatches = 0;
      endfunction

      function void flag(string msg);
         mismatches++;
         if (mismatches <= 10) $display("%0t: %s", $realtime, msg);
      endfunction

      // Entries more recent than the touched one age by one.
      function void promote(int s);
         for (int i = 0; i < ENTRIES; i++)
            if (slot_valid[i] && i != s && slot_rank[i] < slot_rank[s]) slot_rank[i]++;
         slot_rank[s] = 0;
      endfunction

      function void note_request(logic op, key_type key, key_type value);
         int                slot;
         int                victim;
         int unsigned       limit;
         lookup_result_type res;
         slot = -1;
         for (int i = ENTRIES - 1; i >= 0; i--)
            if (slot_valid[i] && slot_key[i] == key) slot = i;
         if (op == OP_GET) begin
            res.key   = key;
            res.hit   = (slot >= 0);
            res.value = (slot >= 0) ? slot_value[slot] : '0;
            if (slot >= 0) promote(slot);
            expected_lookups.push_back(res);
            return;
         end
         if (slot >= 0) begin
            promote(slot);
            slot_value[slot] = value;
            return;
         end
         limit = (capacity == 0) ? 1 : ((capacity > ENTRIES) ? ENTRIES : capacity);
         if (filled >= limit) begin
            // The oldest entry goes; on a tie in rank the lowest index wins.
            victim = -1;
            for (int i = 0; i < ENTRIES; i++)
               if (slot_valid[i] &&
                   (victim < 0 || slot_rank[i] > slot_rank[victim])) victim = i;
            if (victim >= 0) begin
               promote(victim);
               slot_key[victim]   = key;
               slot_value[victim] = value;
               return;
            end
         end
         for (int i = 0; i < ENTRIES; i++) begin
            if (!slot_valid[i]) begin
               for (int j = 0; j < ENTRIES; j++)
                  if (slot_valid[j]) slot_rank[j]++;
               slot_valid[i] = 1'b1;
               slot_key[i]   = key;
               slot_value[i] = value;
               slot_rank[i]  = 0;
               filled++;
               return;
            end
         end
      endfunction

      function void check_lookup(logic hit, key_type value);
         lookup_result_type res;
         if (expected_lookups.size() == 0) begin
            flag($sformatf("response word with no lookup pending: hit %0b value %0d", hit, value));
            return;
         end
         res = expected_lookups.pop_front();
         if (hit !== res.hit || value !== res.value)
            flag($sformatf("lookup of key %0d: expected hit %0b value %0d, got hit %0b value %0d",
                           res.key, res.hit, res.value, hit, value));
      endfunction
   endclass

   logic clock;
   logic reset;

   lkvc_req_if req_if();
   lkvc_rsp_if rsp_if();
   lkvc_csr_if csr_if();

   lookup_checker lookups = new();

   int send_idle_pct;
   int recv_idle_pct;
   bit hold_request;

   lru_key_value_cache u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_if),
      .rsp_chan (rsp_if),
      .csr_chan (csr_if)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // Every accepted word is seen here, at the rising edge, before the block updates.
   always @(posedge clock) begin
      if (!reset) begin
         if (csr_if.valid && csr_if.ready) lookups.capacity = csr_if.capacity_in_use;
         if (req_if.valid && req_if.ready)
            lookups.note_request(req_if.op, req_if.lookup_key, req_if.store_value);
         if (rsp_if.valid && rsp_if.ready) lookups.check_lookup(rsp_if.hit, rsp_if.read_value);
      end
   end

   // Response side: random stalls, plus one long hold-off when asked for.
   initial begin
      int hold_left;
      hold_left    = 0;
      rsp_if.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_if.ready <= 1'b0;
         end else begin
            rsp_if.ready <= ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   task automatic send_request(input logic op, input key_type key, input key_type value);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_if.valid <= 1'b0;
         @(negedge clock);
      end
      req_if.valid       <= 1'b1;
      req_if.op          <= op;
      req_if.lookup_key  <= key;
      req_if.store_value <= value;
      @(posedge clock);
      while (!req_if.ready) @(posedge clock);
   endtask

   // Puts give no response, so a settle wait lets the last one finish.
   task automatic wait_until_drained();
      @(negedge clock);
      req_if.valid <= 1'b0;
      while (lookups.expected_lookups.size() != 0) @(posedge clock);
      repeat (SETTLE_WAIT) @(posedge clock);
   endtask

   task automatic write_capacity(input cap_type cap);
      wait_until_drained();
      @(negedge clock);
      csr_if.valid           <= 1'b1;
      csr_if.capacity_in_use <= cap;
      @(posedge clock);
      while (!csr_if.ready) @(posedge clock);
      @(negedge clock);
      csr_if.valid <= 1'b0;
   endtask

   // Keys come mostly from a small pool so that hits, updates and evictions are common.
   task automatic send_random_items(input int count, input int pool_size);
      key_type pool[$];
      key_type key;
      logic    op;
      for (int i = 0; i < pool_size; i++) pool.push_back(key_type'($urandom));
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(9) == 0) key = key_type'($urandom);
         else key = pool[$urandom_range(pool_size - 1)];
         op = ($urandom_range(99) < 45) ? OP_PUT : OP_GET;
         send_request(op, key, key_type'($urandom));
      end
   endtask

   initial begin
      key_type max_word;
      cap_type cap;
      int      limit;
      max_word               = '1;
      reset                  = 1'b1;
      req_if.valid           = 1'b0;
      req_if.op              = OP_GET;
      req_if.lookup_key      = '0;
      req_if.store_value     = '0;
      csr_if.valid           = 1'b0;
      csr_if.capacity_in_use = '0;
      hold_request           = 1'b0;
      send_idle_pct          = 38;
      recv_idle_pct          = 85;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed part: empty cache, extreme keys and values, update, shrink and clamped capacity.
      send_request(OP_GET, '0, max_word);
      send_request(OP_PUT, '0, max_word);
      send_request(OP_PUT, max_word, '0);
      send_request(OP_GET, '0, '0);
      send_request(OP_GET, max_word, '0);
      send_request(OP_PUT, '0, 31'd1234);
      send_request(OP_GET, '0, '0);
      send_request(OP_GET, 31'd12345, '0);
      send_request(OP_PUT, 31'd1, 31'd11);
      send_request(OP_PUT, 31'd2, 31'd22);
      send_request(OP_PUT, 31'd3, 31'd33);
      send_request(OP_GET, max_word, '0);
      // Capacity drops below the number of entries already held.
      write_capacity(5'd2);
      send_request(OP_GET, 31'd1, '0);
      send_request(OP_PUT, 31'd4, 31'd44);
      send_request(OP_GET, '0, '0);
      send_request(OP_GET, 31'd4, '0);
      write_capacity(5'd0);
      send_request(OP_PUT, 31'd5, 31'd55);
      send_request(OP_GET, 31'd5, '0);
      send_request(OP_GET, 31'd4, '0);
      write_capacity(5'd31);
      send_request(OP_PUT, 31'd6, max_word);
      send_request(OP_GET, 31'd6, '0);
      send_request(OP_GET, 31'd2, '0);

      for (int p = 0; p < 6; p++) begin
         case (p)
            0:       cap = 5'd1;
            1:       cap = 5'd16;
            2:       cap = 5'd3;
            3:       cap = 5'd31;
            4:       cap = 5'd8;
            default: cap = cap_type'($urandom_range(0, 31));
         endcase
         write_capacity(cap);
         case (p % 3)
            0: begin
               send_idle_pct = 38;
               recv_idle_pct = 85;
            end
            1: begin
               send_idle_pct = 85;
               recv_idle_pct = 38;
            end
            default: begin
               send_idle_pct = 0;
               recv_idle_pct = 0;
               hold_request  = 1'b1;
            end
         endcase
         limit = (cap == 0) ? 1 : ((cap > ENTRIES) ? ENTRIES : cap);
         send_random_items(RANDOM_ITEMS, limit + $urandom_range(1, 6));
      end

      wait_until_drained();
      if (lookups.mismatches == 0 && lookups.expected_lookups.size() == 0) begin
         $display("No mismatches found");
      end else begin
         $display("Mismatches found");
      end
      $finish;
   end

   initial begin
      #2_000_000;
      $display("Mismatches found");
      $finish;
   end

endmodule

// ===== lru_key_value_cache.f =====
design/lkvc_pkg.sv
design/lkvc_channels.sv
design/lkvc_cell.sv
design/lru_key_value_cache.sv
tb/sv/lru_key_value_cache_tb.sv
